// ===== src/zbu_pkg.sv =====
package zbu_pkg;

    // Parser phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_TAG    = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    // Widest group the block supports, and the width of a run length up to it
    localparam int MAX_GROUP = 8;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);

    // Request from the parser to the output buffer
    typedef struct packed {
        logic             valid;   // load a run this cycle
        logic             err;     // stream ended in header or group
        logic [CNT_W-1:0] count;   // bytes in the run (ignored on error)
    } t_emit;

endpackage

// ===== src/zero_byte_unpacker.sv =====
// Zero-byte unpacker. Takes the packed stream one byte per transfer on the
// s_axis side (tlast on the final byte): HEADER_BYTES length bytes, most
// significant first, then groups of TAG_BYTES tag bytes plus one data byte per
// set bit of the first tag byte. Each finished group leaves on m_axis as a run
// of GROUP_BYTES bytes, the final one cut to length mod GROUP_BYTES when that
// is nonzero; tlast marks the last byte of each run. A stream that ends inside
// the header or a group gives a single byte 0 with tuser high. Header, tag and
// data bytes that finish no group are taken every cycle while the output run
// register is empty. A byte that finishes a group loads its run, of up to
// GROUP_BYTES bytes, into that register, so the next byte is taken in the
// cycle the last byte of that run transfers. Results appear in the cycle
// after the byte that causes them.
module zero_byte_unpacker #(
    parameter int GROUP_BYTES  = 8,
    parameter int HEADER_BYTES = 4,
    parameter int TAG_BYTES    = 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] status
    output logic       m_axis_tlast
);
    import zbu_pkg::*;

    logic                     w_accept;
    t_emit                    w_emit;
    logic [GROUP_BYTES*8-1:0] w_group;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Header, tag and data parsing
    zbu_parse #(
        .GROUP_BYTES (GROUP_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .TAG_BYTES   (TAG_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_byte  (s_axis_tdata),
        .i_eos   (s_axis_tlast),
        .o_emit  (w_emit),
        .o_group (w_group)
    );

    // Output run register
    zbu_drain #(
        .GROUP_BYTES(GROUP_BYTES)
    ) u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_group (w_group),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_status(m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== src/zbu_parse.sv =====
module zbu_parse #(
    parameter int GROUP_BYTES  = 8,
    parameter int HEADER_BYTES = 4,
    parameter int TAG_BYTES    = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_byte,
    input  logic                     i_eos,
    output zbu_pkg::t_emit           o_emit,
    output logic [GROUP_BYTES*8-1:0] o_group
);
    import zbu_pkg::*;

    localparam int TAILW = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
    localparam int HCW   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int TCW   = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
    // tail = length mod group, built a byte at a time: t' = (t*256 + b) mod G
    localparam logic [8:0]  TAIL_R = 9'(256 % GROUP_BYTES);
    localparam logic [16:0] RECIP  = 17'((65536 + GROUP_BYTES - 1) / GROUP_BYTES);

    logic [1:0]               r_phase, n_phase;
    logic [HCW-1:0]           r_hcnt, n_hcnt;
    logic [TAILW-1:0]         r_tail, n_tail;
    logic [TCW-1:0]           r_tcnt, n_tcnt;
    logic [GROUP_BYTES-1:0]   r_tag, n_tag;
    logic [GROUP_BYTES*8-1:0] r_grp, n_grp;
    t_emit                    w_emit;

    logic [8:0]  w_v;
    logic [25:0] w_prod;
    logic [9:0]  w_q;
    logic [8:0]  w_rem;

    // Running remainder: reciprocal multiply is exact for these narrow values
    assign w_v    = 9'(r_tail) * TAIL_R + {1'b0, i_byte};
    assign w_prod = 26'(w_v) * 26'(RECIP);
    assign w_q    = w_prod[25:16];
    assign w_rem  = w_v - 9'(w_q * 10'(GROUP_BYTES));

    // Next state and run request
    always_comb begin
        logic found;
        found   = 1'b0;
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_tail  = r_tail;
        n_tcnt  = r_tcnt;
        n_tag   = r_tag;
        n_grp   = r_grp;
        w_emit  = '0;
        if (i_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    n_tail = w_rem[TAILW-1:0];
                    if (r_hcnt == HCW'(HEADER_BYTES - 1)) begin
                        n_phase = PH_TAG;
                        n_hcnt  = '0;
                        n_tcnt  = '0;
                    end else begin
                        n_hcnt = r_hcnt + 1'b1;
                        if (i_eos) begin
                            w_emit.valid = 1'b1;
                            w_emit.err   = 1'b1;
                        end
                    end
                end
                PH_TAG: begin
                    // only the first tag byte of a group carries the map
                    if (r_tcnt == '0) begin
                        n_grp = '0;
                        n_tag = i_byte[GROUP_BYTES-1:0];
                    end
                    if (r_tcnt == TCW'(TAG_BYTES - 1)) begin
                        n_tcnt = '0;
                        if (n_tag == '0) begin
                            w_emit.valid = 1'b1;
                            w_emit.count = (i_eos && r_tail != '0) ?
                                           CNT_W'(r_tail) : CNT_W'(GROUP_BYTES);
                        end else if (i_eos) begin
                            w_emit.valid = 1'b1;
                            w_emit.err   = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_tcnt = r_tcnt + 1'b1;
                        if (i_eos) begin
                            w_emit.valid = 1'b1;
                            w_emit.err   = 1'b1;
                        end
                    end
                end
                PH_DATA: begin
                    // data byte lands at the lowest position still waiting
                    for (int pos = 0; pos < GROUP_BYTES; pos++) begin
                        if (!found && r_tag[pos]) begin
                            found            = 1'b1;
                            n_grp[pos*8 +: 8] = i_byte;
                            n_tag[pos]       = 1'b0;
                        end
                    end
                    if (n_tag == '0) begin
                        n_phase      = PH_TAG;
                        w_emit.valid = 1'b1;
                        w_emit.count = (i_eos && r_tail != '0) ?
                                       CNT_W'(r_tail) : CNT_W'(GROUP_BYTES);
                    end else if (i_eos) begin
                        w_emit.valid = 1'b1;
                        w_emit.err   = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
            // end of stream returns to the start of a new stream
            if (i_eos) begin
                n_phase = PH_HEADER;
                n_hcnt  = '0;
                n_tail  = '0;
                n_tcnt  = '0;
                n_tag   = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hcnt  <= '0;
            r_tail  <= '0;
            r_tcnt  <= '0;
            r_tag   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_tail  <= n_tail;
            r_tcnt  <= n_tcnt;
            r_tag   <= n_tag;
        end
    end

    // Group being assembled
    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    assign o_emit  = w_emit;
    assign o_group = n_grp;

endmodule

// ===== src/zbu_drain.sv =====
module zbu_drain #(
    parameter int GROUP_BYTES = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  zbu_pkg::t_emit           i_emit,
    input  logic [GROUP_BYTES*8-1:0] i_group,
    output logic                     o_ready,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_byte,
    output logic                     o_status,
    output logic                     o_last
);
    import zbu_pkg::*;

    logic [CNT_W-1:0]         r_cnt;
    logic [GROUP_BYTES*8-1:0] r_buf;
    logic                     r_err;
    logic                     w_take;

    assign o_valid = (r_cnt != '0);
    assign o_last  = (r_cnt == CNT_W'(1));
    assign w_take  = o_valid && i_ready;
    // free for a new run when empty or when the final byte leaves now
    assign o_ready = !o_valid || (w_take && o_last);

    assign o_byte   = r_buf[7:0];
    assign o_status = r_err;

    // Bytes left in the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_emit.valid) begin
            r_cnt <= i_emit.err ? CNT_W'(1) : i_emit.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Run payload, lowest byte out first
    always_ff @(posedge i_clk) begin
        if (i_emit.valid) begin
            r_buf <= i_emit.err ? '0 : i_group;
            r_err <= i_emit.err;
        end else if (w_take) begin
            r_buf <= r_buf >> 8;
        end
    end

endmodule

// ===== tb/zero_byte_unpacker_tb.sv =====
`timescale 1ns / 1ps

module zero_byte_unpacker_tb;

    import zbu_pkg::*;

    localparam int GROUP_BYTES  = 8;
    localparam int HEADER_BYTES = 4;
    localparam int TAG_BYTES    = 1;

    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_NS     = 5_000_000;

    // Kinds of stream the random part builds
    typedef enum int {
        STREAM_FULL,
        STREAM_SHORT_HEADER,
        STREAM_HEADER_ONLY,
        STREAM_CUT_GROUP
    } t_stream_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       is_last;
    } t_out_byte;

    typedef struct packed {
        logic       eos;
        logic [7:0] data;
    } t_in_byte;

    // Tracks the unpacker state and the bytes still owed on the output
    class unpack_scoreboard #(int GROUP_N = 8, int HEADER_N = 4, int TAG_N = 1);
        logic [1:0]  phase;
        int unsigned header_taken;
        logic [31:0] length;
        int unsigned tail;
        logic [7:0]  open_bits;
        int unsigned tag_taken;
        int unsigned data_due;
        logic [7:0]  group [8];
        t_out_byte   owed_q [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            phase        = PH_HEADER;
            header_taken = 0;
            length       = '0;
            tail         = 0;
            open_bits    = '0;
            tag_taken    = 0;
            data_due     = 0;
            foreach (group[k]) group[k] = '0;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void owe_error();
            owed_q.push_back('{data: 8'h00, err: 1'b1, is_last: 1'b1});
        endfunction

        // Final group is cut to the tail when the tail is nonzero
        function void owe_group(logic final_grp);
            int unsigned n;
            n = (final_grp && tail != 0) ? tail : GROUP_N;
            for (int unsigned k = 0; k < n; k++)
                owed_q.push_back('{data: group[k], err: 1'b0, is_last: (k + 1 == n)});
        endfunction

        // One transfer accepted on the input side
        function void note_input(logic [7:0] b, logic eos);
            logic placed;
            placed = 1'b0;
            case (phase)
                PH_HEADER: begin
                    length = {length[23:0], b};
                    header_taken++;
                    if (header_taken >= HEADER_N) begin
                        tail      = length % GROUP_N;
                        phase     = PH_TAG;
                        tag_taken = 0;
                    end else if (eos) begin
                        owe_error();
                    end
                end
                PH_TAG: begin
                    if (tag_taken == 0) begin
                        foreach (group[k]) group[k] = '0;
                        open_bits = b & 8'((1 << GROUP_N) - 1);
                        data_due  = $countones(open_bits);
                    end
                    tag_taken++;
                    if (tag_taken >= TAG_N) begin
                        tag_taken = 0;
                        if (data_due == 0)
                            owe_group(eos);
                        else if (eos)
                            owe_error();
                        else
                            phase = PH_DATA;
                    end else if (eos) begin
                        owe_error();
                    end
                end
                default: begin
                    // data byte fills the lowest position still open
                    for (int pos = 0; pos < GROUP_N; pos++) begin
                        if (!placed && open_bits[pos]) begin
                            group[pos]     = b;
                            open_bits[pos] = 1'b0;
                            placed         = 1'b1;
                        end
                    end
                    if (data_due > 0)
                        data_due--;
                    if (data_due == 0) begin
                        owe_group(eos);
                        phase = PH_TAG;
                    end else if (eos) begin
                        owe_error();
                    end
                end
            endcase
            if (eos)
                clear();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // One transfer accepted on the output side
        task check_result(logic [7:0] d, logic st, logic lst);
            t_out_byte want;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected byte %02h status %0b last %0b", d, st, lst));
                return;
            end
            want = owed_q.pop_front();
            if (d !== want.data)
                report($sformatf("out_byte %02h, wanted %02h", d, want.data));
            if (st !== want.err)
                report($sformatf("status %0b, wanted %0b", st, want.err));
            if (lst !== want.is_last)
                report($sformatf("last_of_run %0b, wanted %0b", lst, want.is_last));
        endtask
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;    // end_of_stream
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tuser;            // [0] status
    logic       m_axis_tlast;            // last_of_run

    unpack_scoreboard #(GROUP_BYTES, HEADER_BYTES, TAG_BYTES) sb;

    t_in_byte   stream_q [$];
    bit         tx_burst = 1'b0;

    zero_byte_unpacker #(
        .GROUP_BYTES  (GROUP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .TAG_BYTES    (TAG_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(bit no_gap);
        int r;
        r = $urandom_range(0, 99);
        if (no_gap || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Empty tags and full tags turn up more often than plain chance gives
    function automatic logic [7:0] pick_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'h00;
        if (r < 35)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic eos);
        stream_q.push_back('{eos: eos, data: b});
    endfunction

    function automatic void build_stream(t_stream_kind kind);
        int         n;
        int         cut;
        int         n_groups;
        int         pop;
        logic [7:0] tag;
        if (kind == STREAM_SHORT_HEADER) begin
            n = $urandom_range(1, HEADER_BYTES - 1);
            for (int k = 0; k < n; k++)
                queue_byte(8'($urandom), k == n - 1);
            return;
        end
        for (int k = 0; k < HEADER_BYTES; k++)
            queue_byte(8'($urandom), kind == STREAM_HEADER_ONLY && k == HEADER_BYTES - 1);
        if (kind == STREAM_HEADER_ONLY)
            return;
        n_groups = $urandom_range(1, 4);
        for (int g = 0; g < n_groups; g++) begin
            tag = pick_tag();
            if (kind == STREAM_CUT_GROUP && g == n_groups - 1) begin
                // stream ends on the tag or part way through the data
                if (tag == 8'h00)
                    tag = 8'h01 << $urandom_range(0, 7);
                pop = $countones(tag);
                cut = $urandom_range(0, pop - 1);
                queue_byte(tag, cut == 0);
                for (int j = 0; j < cut; j++)
                    queue_byte(8'($urandom), j == cut - 1);
            end else begin
                pop = $countones(tag);
                queue_byte(tag, pop == 0 && g == n_groups - 1);
                for (int j = 0; j < pop; j++)
                    queue_byte(8'($urandom), g == n_groups - 1 && j == pop - 1);
            end
        end
    endfunction

    // One input transfer, with an optional gap before it
    task automatic send_byte(t_in_byte item);
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.data;
        s_axis_tlast  <= item.eos;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(item.data, item.eos);
    endtask

    task automatic send_queued(output int sent);
        sent = stream_q.size();
        while (stream_q.size() != 0)
            send_byte(stream_q.pop_front());
    endtask

    // Input goes idle, then waits until nothing is owed
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Output side: random back-pressure plus one long hold-off
    initial begin : rx_side
        int unsigned stall  = 0;
        int unsigned seen   = 0;
        bit          held   = 1'b0;
        bit          rx_run = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                seen++;
                if (seen % 40 == 0)
                    rx_run = ($urandom_range(0, 2) == 0);
                if (!held && seen == HOLD_AT) begin
                    held  = 1'b1;
                    stall = HOLD_CYCLES;
                end else begin
                    stall = pick_gap(rx_run);
                end
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int           sent;
        int           random_sent;
        int           r;
        t_stream_kind kind;
        sb          = new();
        random_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Length 0: a full tag with every data position, then an empty final tag
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b0);
        queue_byte(8'h55, 1'b0); queue_byte(8'hAA, 1'b0);
        queue_byte(8'h01, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b0); queue_byte(8'hFE, 1'b0);
        queue_byte(8'h00, 1'b1);
        // Tail of 5 with an empty final tag: run is still cut
        queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0); queue_byte(8'hFD, 1'b0);
        queue_byte(8'h00, 1'b1);
        // Stream ends inside the header
        queue_byte(8'h5A, 1'b1);
        // Stream ends right after the header: nothing comes out
        queue_byte(8'h12, 1'b0); queue_byte(8'h34, 1'b0);
        queue_byte(8'h56, 1'b0); queue_byte(8'h78, 1'b1);
        // Stream ends with data still due in the group
        queue_byte(8'h01, 1'b0); queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b0); queue_byte(8'h04, 1'b0);
        queue_byte(8'h81, 1'b0); queue_byte(8'hC3, 1'b1);
        send_queued(sent);
        wait_drained();

        // Random streams, mostly well formed
        while (random_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                kind = STREAM_FULL;
            else if (r == 7)
                kind = STREAM_SHORT_HEADER;
            else if (r == 8)
                kind = STREAM_HEADER_ONLY;
            else
                kind = STREAM_CUT_GROUP;
            tx_burst = ($urandom_range(0, 3) == 0);
            build_stream(kind);
            send_queued(sent);
            random_sent += sent;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
